[hw/rtl/dbrm_pkg.sv]
// ----------------------------------------------------------------------------
// dbrm_pkg
// Shared types, codes, constants and the CRC-16/Modbus byte step for the
// dual-bank record manager.
// ----------------------------------------------------------------------------
`default_nettype none

package dbrm_pkg;

    // stream widths
    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 56;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // queue depth between front and back, default
    localparam int QUEUE_DEPTH_DEF = 2;

    // operation codes carried in tuser
    localparam logic [S_TUSER_W-1:0] OP_TICK  = 3'd0;
    localparam logic [S_TUSER_W-1:0] OP_BYTE  = 3'd1;
    localparam logic [S_TUSER_W-1:0] OP_CHECK = 3'd2;
    localparam logic [S_TUSER_W-1:0] OP_BOOT  = 3'd3;
    localparam logic [S_TUSER_W-1:0] OP_SAVE  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 1'd1;

    // constants
    localparam logic [15:0] REC_MAGIC         = 16'hA5A5;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] VERSION_RESET     = 16'd1;
    localparam logic [7:0]  DEBOUNCE_RESET    = 8'd20;

    // item class decided by the front
    typedef enum logic [2:0] {
        K_TICK,
        K_BYTE,
        K_CHECK,
        K_BOOT,
        K_SAVE,
        K_IDLE
    } t_kind;

    // classified item as held in the queue
    typedef struct packed {
        t_kind       kind;
        logic        chg;
        logic [7:0]  data;
        logic        last;
        logic        rsel;
        logic        magic_ok;
        logic [15:0] ver;
        logic [15:0] hcrc;
        logic [31:0] hseq;
        logic        ok;
    } t_work;

    // queue head as seen by the back
    typedef struct packed {
        logic  valid;
        t_work work;
    } t_head;

    // one payload byte through the reflected CRC-16/Modbus polynomial
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dual_bank_record_manager.sv]
// ----------------------------------------------------------------------------
// dual_bank_record_manager
// Ping-pong record bookkeeping for two flash regions with CRC-16/Modbus check.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the slave stream: tuser carries the operation code, tlast
//   marks the final payload byte, tdata the remaining fields. Each item gives
//   exactly one result item on the master stream (save command, target,
//   write sequence, CRC, header verdict, boot choice, active region).
//   Registers (expected version, debounce ticks) are written on the cfg
//   channel, index 0 and 1, while no item is in flight; cfg is ready
//   whenever reset is released.
// Path: an accepted item is written into the queue, and the back end carries
//   it from the queue head into the output register.
// Throughput: one item per cycle unless stalled; the classified item waits in
//   a queue of QUEUE_DEPTH entries and the back end carries out one item per
//   cycle, while the output is free, into a single output register.
// Stall: while the receiver holds tready low the result stays put; the queue
//   keeps accepting until it is full, then o_s_tready drops.
// Reset: queue and output empty, CRC engine at 0xFFFF, banks invalid,
//   no active region, sequence 0, registers back to version 1 and 20 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_bank_record_manager #(
    parameter int QUEUE_DEPTH = dbrm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // slave stream
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: change_request[0], data_byte[8:1], region_select[9],
    //   header_magic[25:10], header_version[41:26], header_crc[57:42],
    //   header_sequence[89:58], save_ok[90], zero fill [95:91]
    input  wire [dbrm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: op[2:0]
    input  wire [dbrm_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  wire                             i_s_tlast,      // last_byte
    // master stream
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // tdata: save_command[0], target_region[1], write_sequence[33:2],
    //   crc_value[49:34], region_valid[50], load_params[51],
    //   chosen_region[52], active_valid[53], active_region[54], zero [55]
    output logic [dbrm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // configuration writes
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [dbrm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [dbrm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dbrm_pkg::*;

    logic [15:0] r_expected_version;
    logic [7:0]  r_debounce_ticks;
    t_head       w_head;
    logic        w_pop;

    assign o_cfg_ready = i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_RESET;
            r_debounce_ticks   <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_expected_version <= i_cfg_data;
                CFG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept, classify, queue
    dbrm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // back: execute and register results
    dbrm_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .i_expected_version (r_expected_version),
        .i_debounce_ticks   (r_debounce_ticks),
        .o_m_tvalid         (o_m_tvalid),
        .i_m_tready         (i_m_tready),
        .o_m_tdata          (o_m_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/dbrm_front.sv]
// ----------------------------------------------------------------------------
// dbrm_front
// Accepts input items, classifies them by operation code and holds them in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrm_front #(
    parameter int QUEUE_DEPTH = dbrm_pkg::QUEUE_DEPTH_DEF   // 2 and up
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [dbrm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire [dbrm_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input  wire                            i_s_tlast,
    output dbrm_pkg::t_head                o_head,
    input  wire                            i_pop
);
    import dbrm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work              r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    t_work              w_in;
    logic               w_push;
    logic               w_pop;

    // classify the incoming item
    always_comb begin
        w_in.chg      = i_s_tdata[0];
        w_in.data     = i_s_tdata[8:1];
        w_in.last     = i_s_tlast;
        w_in.rsel     = i_s_tdata[9];
        w_in.magic_ok = (i_s_tdata[25:10] == REC_MAGIC);
        w_in.ver      = i_s_tdata[41:26];
        w_in.hcrc     = i_s_tdata[57:42];
        w_in.hseq     = i_s_tdata[89:58];
        w_in.ok       = i_s_tdata[90];
        case (i_s_tuser)
            OP_TICK:  w_in.kind = K_TICK;
            OP_BYTE:  w_in.kind = K_BYTE;
            OP_CHECK: w_in.kind = K_CHECK;
            OP_BOOT:  w_in.kind = K_BOOT;
            OP_SAVE:  w_in.kind = K_SAVE;
            default:  w_in.kind = K_IDLE;
        endcase
    end

    // no item is taken while reset is held
    assign o_s_tready = i_rst_n && (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.work  = r_q[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_in;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dbrm_back.sv]
// ----------------------------------------------------------------------------
// dbrm_back
// Carries out classified items against the record state (CRC engine, bank
// verdicts, debounce, active region, sequence) and registers one result item
// per item on the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrm_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  dbrm_pkg::t_head                i_head,
    output logic                           o_pop,
    input  wire [15:0]                     i_expected_version,
    input  wire [7:0]                      i_debounce_ticks,
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [dbrm_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import dbrm_pkg::*;

    // record state
    logic [15:0] r_crc_running, n_crc_running;
    logic [15:0] r_crc_latched, n_crc_latched;
    logic        r_bank_valid_a, n_bank_valid_a;
    logic        r_bank_valid_b, n_bank_valid_b;
    logic [31:0] r_bank_seq_a, n_bank_seq_a;
    logic [31:0] r_bank_seq_b, n_bank_seq_b;
    logic [7:0]  r_holdoff, n_holdoff;
    logic        r_cur_valid, n_cur_valid;
    logic        r_cur_region, n_cur_region;
    logic [31:0] r_seq_next, n_seq_next;
    logic        r_pending, n_pending;

    // output stage
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    // per-item result fields
    logic        w_save;
    logic        w_target;
    logic [31:0] w_wseq;
    logic        w_wseq_set;
    logic [15:0] w_crcv;
    logic        w_rvalid;
    logic        w_load;
    logic        w_chosen;
    logic [15:0] w_crc_step;
    logic [7:0]  w_hold_dec;
    logic        w_exec;
    t_work       w_w;

    assign w_w    = i_head.work;
    assign w_exec = i_head.valid && (!r_m_tvalid || i_m_tready);
    assign o_pop  = w_exec;

    assign w_crc_step = crc16_byte(r_crc_running, w_w.data);
    assign w_hold_dec = r_holdoff - 8'd1;

    // execute the head item
    always_comb begin
        n_crc_running  = r_crc_running;
        n_crc_latched  = r_crc_latched;
        n_bank_valid_a = r_bank_valid_a;
        n_bank_valid_b = r_bank_valid_b;
        n_bank_seq_a   = r_bank_seq_a;
        n_bank_seq_b   = r_bank_seq_b;
        n_holdoff      = r_holdoff;
        n_cur_valid    = r_cur_valid;
        n_cur_region   = r_cur_region;
        n_seq_next     = r_seq_next;
        n_pending      = r_pending;
        w_save         = 1'b0;
        w_target       = 1'b0;
        w_wseq         = '0;
        w_wseq_set     = 1'b0;
        w_crcv         = r_crc_latched;
        w_rvalid       = 1'b0;
        w_load         = 1'b0;
        w_chosen       = 1'b0;
        case (w_w.kind)
            K_TICK: begin
                // change request restarts the holdoff, expiry commands a save
                if (w_w.chg) begin
                    n_holdoff = i_debounce_ticks;
                end else if (r_holdoff != 8'd0) begin
                    n_holdoff = w_hold_dec;
                    if (w_hold_dec == 8'd0) begin
                        w_target   = !(r_cur_valid && r_cur_region);
                        n_pending  = w_target;
                        w_save     = 1'b1;
                        w_wseq     = r_seq_next;
                        w_wseq_set = 1'b1;
                    end
                end
            end
            K_BYTE: begin
                w_crcv = w_crc_step;
                if (w_w.last) begin
                    n_crc_latched = w_crc_step;
                    n_crc_running = CRC_INIT;
                end else begin
                    n_crc_running = w_crc_step;
                end
            end
            K_CHECK: begin
                w_rvalid = w_w.magic_ok && (w_w.ver == i_expected_version) &&
                           (w_w.hcrc == r_crc_latched);
                if (w_w.rsel) begin
                    n_bank_valid_b = w_rvalid;
                    n_bank_seq_b   = w_w.hseq;
                end else begin
                    n_bank_valid_a = w_rvalid;
                    n_bank_seq_a   = w_w.hseq;
                end
            end
            K_BOOT: begin
                // higher sequence wins, A on a tie
                if (r_bank_valid_a || r_bank_valid_b) begin
                    if (r_bank_valid_a && r_bank_valid_b) begin
                        w_chosen = (r_bank_seq_a < r_bank_seq_b);
                    end else begin
                        w_chosen = !r_bank_valid_a;
                    end
                    w_load       = 1'b1;
                    n_cur_valid  = 1'b1;
                    n_cur_region = w_chosen;
                    n_seq_next   = (w_chosen ? r_bank_seq_b : r_bank_seq_a) + 32'd1;
                end else begin
                    // nothing valid: default save to A
                    n_seq_next = '0;
                    n_pending  = 1'b0;
                    w_save     = 1'b1;
                    w_target   = 1'b0;
                    w_wseq     = '0;
                    w_wseq_set = 1'b1;
                end
            end
            K_SAVE: begin
                if (w_w.ok) begin
                    n_cur_region = r_pending;
                    n_cur_valid  = 1'b1;
                    n_seq_next   = r_seq_next + 32'd1;
                end
            end
            default: begin
            end
        endcase
        if (!w_wseq_set) begin
            w_wseq = n_seq_next;
        end
        n_m_tdata = {1'b0, n_cur_region, n_cur_valid, w_chosen, w_load, w_rvalid,
                     w_crcv, w_wseq, w_target, w_save};
    end

    // state registers, updated only when an item is carried out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_running  <= CRC_INIT;
            r_crc_latched  <= '0;
            r_bank_valid_a <= 1'b0;
            r_bank_valid_b <= 1'b0;
            r_bank_seq_a   <= '0;
            r_bank_seq_b   <= '0;
            r_holdoff      <= '0;
            r_cur_valid    <= 1'b0;
            r_cur_region   <= 1'b0;
            r_seq_next     <= '0;
            r_pending      <= 1'b0;
            r_m_tvalid     <= 1'b0;
        end else begin
            if (w_exec) begin
                r_crc_running  <= n_crc_running;
                r_crc_latched  <= n_crc_latched;
                r_bank_valid_a <= n_bank_valid_a;
                r_bank_valid_b <= n_bank_valid_b;
                r_bank_seq_a   <= n_bank_seq_a;
                r_bank_seq_b   <= n_bank_seq_b;
                r_holdoff      <= n_holdoff;
                r_cur_valid    <= n_cur_valid;
                r_cur_region   <= n_cur_region;
                r_seq_next     <= n_seq_next;
                r_pending      <= n_pending;
                r_m_tvalid     <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid     <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

`default_nettype wire

[hw/rtl/dbrm_checker.sv]
// ----------------------------------------------------------------------------
// dbrm_checker
// Port-level checks for the dual-bank record manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbrm_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_m_tvalid,
    input wire                            i_m_tready,
    input wire [dbrm_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result item present after reset");

    // a stalled result item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result item changed");

    // target only meaningful with a save command
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> !o_m_tdata[1])
        else $error("target region set without save command");

    // a boot load makes the chosen region active
    a_load_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[51] |-> o_m_tdata[53] && (o_m_tdata[54] == o_m_tdata[52]))
        else $error("loaded region is not the active one");

    // a save command and a load never come from the same item
    a_save_or_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[51]))
        else $error("save and load in one result item");

endmodule

bind dual_bank_record_manager dbrm_checker u_dbrm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
